>>> hdl/wlfa_pkg.sv
package wlfa_pkg;

  localparam int MAX_HITS_DEF = 64;
  localparam int W_SHIFT      = 24;
  localparam int TX_SHIFT     = 14;
  localparam logic [127:0] DEN_THRESH = 128'd1678;

  // One classified hit as it travels from the front end to the arithmetic back end
  typedef struct packed {
    logic               remove;
    logic               act;
    logic signed [14:0] z;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [31:0]        rr;
    logic [19:0]        hw;
    logic signed [15:0] phi;
    logic               unused;
  } item_t;

endpackage

>>> hdl/wlfa_mul.sv
module wlfa_mul import wlfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);

  logic [63:0]  ar;
  logic [63:0]  br;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  pp;
  logic [127:0] part;

  always_comb begin
    unique case (cnt)
      3'd0: begin ma = ar[31:0];  mb = br[31:0];  end
      3'd1: begin ma = ar[31:0];  mb = br[63:32]; end
      3'd2: begin ma = ar[63:32]; mb = br[31:0];  end
      3'd3: begin ma = ar[63:32]; mb = br[63:32]; end
      default: begin ma = ar[31:0]; mb = br[31:0]; end
    endcase
    pp = ma * mb;
    unique case (cnt)
      3'd0:       part = {64'd0, pp};
      3'd1, 3'd2: part = {32'd0, pp, 32'd0};
      3'd3:       part = {pp, 64'd0};
      default:    part = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= busy && !start && (cnt > 3'd4);
      if (start) begin
        ar   <= a;
        br   <= b;
        acc  <= 128'd0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt <= 3'd3) begin
          acc <= acc + part;
        end else if (cnt == 3'd4) begin
          // signed correction of the unsigned partial products
          if (ar[63]) acc[127:64] <= acc[127:64] - br;
        end else begin
          if (br[63]) acc[127:64] <= acc[127:64] - ar;
          busy <= 1'b0;
        end
      end
    end
  end

  assign p = acc;

endmodule

>>> hdl/wlfa_div.sv
module wlfa_div import wlfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  input  logic [7:0]   iters,
  output logic         done,
  output logic [63:0]  quo
);

  logic [127:0] rem;
  logic [127:0] nreg;
  logic [127:0] dreg;
  logic [63:0]  q;
  logic         big;
  logic [7:0]   cnt;
  logic [7:0]   last;
  logic         busy;
  logic [127:0] sh;
  logic         ge;

  always_comb begin
    sh = {rem[126:0], nreg[127]};
    ge = rem[127] || (sh >= dreg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 8'd0;
    end else begin
      done <= busy && !start && (cnt == last);
      if (start) begin
        rem  <= 128'd0;
        nreg <= num;
        dreg <= den;
        last <= iters - 8'd1;
        q    <= 64'd0;
        big  <= 1'b0;
        cnt  <= 8'd0;
        busy <= 1'b1;
      end else if (busy) begin
        nreg <= {nreg[126:0], 1'b0};
        rem  <= ge ? sh - dreg : sh;
        // freeze the quotient once it reaches the cap
        if (!big) begin
          if (q[63] || q[62]) big <= 1'b1;
          else q <= {q[62:0], ge};
        end
        cnt <= cnt + 8'd1;
        if (cnt == last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo = big ? {1'b1, 63'd0} : q;

endmodule

>>> hdl/wlfa_front.sv
module wlfa_front import wlfa_pkg::*; #(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [14:0] z_pos,
  input  logic [15:0]        radius,
  input  logic signed [15:0] cos_phi,
  input  logic signed [15:0] sin_phi,
  input  logic [19:0]        hit_weight,
  input  logic signed [15:0] phi_angle,
  input  logic               is_unused,
  input  logic               q_ready,
  output logic               q_push,
  output item_t              q_item
);

  localparam int CAP = (MAX_HITS < 127) ? MAX_HITS : 127;

  logic [6:0]         cnt;
  logic [15:0]        r_c;
  logic signed [32:0] px;
  logic signed [32:0] py;
  logic               act;

  function automatic logic signed [17:0] rnd_q14(input logic signed [32:0] p);
    logic [32:0] mag;
    logic [16:0] m;
    mag = p[32] ? 33'(-p) : 33'(p);
    m   = 17'((mag + 33'd8192) >> 14);
    return p[32] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  always_comb begin
    r_c = (radius == 16'd0) ? 16'd1 : radius;
    px  = $signed({1'b0, r_c}) * cos_phi;
    py  = $signed({1'b0, r_c}) * sin_phi;
    act = op ? (cnt != 7'd0) : (cnt < 7'(CAP));
    q_item.remove = op;
    q_item.act    = act;
    q_item.z      = z_pos;
    q_item.x      = rnd_q14(px);
    q_item.y      = rnd_q14(py);
    q_item.rr     = r_c * r_c;
    q_item.hw     = hit_weight;
    q_item.phi    = phi_angle;
    q_item.unused = is_unused;
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // shadow hit count decides whether an add or remove takes effect
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 7'd0;
    end else if (q_push && act) begin
      cnt <= op ? cnt - 7'd1 : cnt + 7'd1;
    end
  end

endmodule

>>> hdl/wlfa_queue.sv
module wlfa_queue import wlfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t item_out
);

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign ready    = (cnt != 2'd2);
  assign valid    = (cnt != 2'd0);
  assign item_out = mem[rp];

endmodule

>>> hdl/wlfa_back.sv
module wlfa_back import wlfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  item_t              q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_intercept,
  output logic signed [31:0] y_intercept,
  output logic signed [21:0] x_slope,
  output logic signed [21:0] y_slope,
  output logic signed [15:0] mean_phi,
  output logic [6:0]         hit_total,
  output logic [6:0]         unused_total,
  output logic               degenerate
);

  typedef enum logic [3:0] {
    B_IDLE, B_WSTART, B_WWAIT, B_PSTART, B_PWAIT, B_UPD,
    B_FSTART, B_FWAIT, B_DCHK, B_DSTART, B_DWAIT, B_FIN
  } bstate_t;

  bstate_t      state;
  item_t        cur;
  logic [44:0]  w;
  logic [63:0]  hwx, hwy, hwz, hwxz, hwyz, hwzz;
  logic [63:0]  s_w, s_wx, s_wy, s_wz, s_wxz, s_wyz, s_wzz;
  logic [23:0]  s_phi;
  logic [6:0]   hc, uc;
  logic [2:0]   pidx;
  logic [3:0]   fidx;
  logic [2:0]   didx;
  logic [127:0] tmp, den, den_mag;
  logic         den_neg;
  logic [127:0] nums [4];
  logic         degen;
  logic [31:0]  rx0, ry0;
  logic [21:0]  rtx, rty;
  logic [15:0]  rphi;

  logic         mul_start;
  logic [63:0]  mul_a, mul_b;
  logic         mul_done;
  logic [127:0] mul_p;
  logic         div_start;
  logic [127:0] div_num, div_den;
  logic [7:0]   div_iters;
  logic         div_done;
  logic [63:0]  quo;

  logic [63:0]  w64, x64, y64, z64;
  logic [63:0]  pa, pb, fa, fb;
  logic [127:0] dabs, nsel, nabs;
  logic [23:0]  phi_mag;
  logic         qneg;

  function automatic logic [31:0] sat32(input logic [63:0] q, input logic neg);
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
  endfunction

  function automatic logic [21:0] sat22(input logic [63:0] q, input logic neg);
    if (neg) return (q >= 64'h20_0000) ? 22'h20_0000 : 22'(-q);
    return (q > 64'h1f_ffff) ? 22'h1f_ffff : q[21:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [63:0] q, input logic neg);
    if (neg) return (q >= 64'h8000) ? 16'h8000 : 16'(-q);
    return (q > 64'h7fff) ? 16'h7fff : q[15:0];
  endfunction

  wlfa_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  wlfa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .iters(div_iters), .done(div_done), .quo(quo)
  );

  always_comb begin
    w64 = {19'd0, w};
    x64 = {{46{cur.x[17]}}, cur.x};
    y64 = {{46{cur.y[17]}}, cur.y};
    z64 = {{49{cur.z[14]}}, cur.z};
    unique case (pidx)
      3'd0:    begin pa = w64; pb = x64; end
      3'd1:    begin pa = w64; pb = y64; end
      3'd2:    begin pa = w64; pb = z64; end
      3'd3:    begin pa = hwx; pb = z64; end
      3'd4:    begin pa = hwy; pb = z64; end
      default: begin pa = hwz; pb = z64; end
    endcase
    unique case (fidx)
      4'd0:    begin fa = s_wzz; fb = s_w;   end
      4'd1:    begin fa = s_wz;  fb = s_wz;  end
      4'd2:    begin fa = s_wx;  fb = s_wzz; end
      4'd3:    begin fa = s_wxz; fb = s_wz;  end
      4'd4:    begin fa = s_wy;  fb = s_wzz; end
      4'd5:    begin fa = s_wyz; fb = s_wz;  end
      4'd6:    begin fa = s_wxz; fb = s_w;   end
      4'd7:    begin fa = s_wx;  fb = s_wz;  end
      4'd8:    begin fa = s_wyz; fb = s_w;   end
      default: begin fa = s_wy;  fb = s_wz;  end
    endcase
    dabs    = den[127] ? -den : den;
    nsel    = nums[didx[1:0]];
    nabs    = nsel[127] ? -nsel : nsel;
    phi_mag = s_phi[23] ? -s_phi : s_phi;
    qneg    = nsel[127] ^ den_neg;
  end

  assign q_pop = (state == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      s_w   <= 64'd0; s_wx  <= 64'd0; s_wy  <= 64'd0; s_wz <= 64'd0;
      s_wxz <= 64'd0; s_wyz <= 64'd0; s_wzz <= 64'd0;
      s_phi <= 24'd0;
      hc    <= 7'd0;
      uc    <= 7'd0;
    end else begin
      mul_start <= (state == B_PSTART) || (state == B_FSTART);
      div_start <= (state == B_WSTART) ||
                   (state == B_DSTART && (didx != 3'd4 || hc != 7'd0));
      if (out_valid && out_ready && state != B_FIN) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            fidx  <= 4'd0;
            state <= q_item.act ? B_WSTART : B_FSTART;
          end
        end
        B_WSTART: begin
          div_num   <= {84'd0, cur.hw, 24'd0};
          div_den   <= {96'd0, cur.rr};
          div_iters <= 8'd128;
          state     <= B_WWAIT;
        end
        B_WWAIT: begin
          if (div_done) begin
            w     <= quo[44:0];
            pidx  <= 3'd0;
            state <= B_PSTART;
          end
        end
        B_PSTART: begin
          mul_a     <= pa;
          mul_b     <= pb;
          state     <= B_PWAIT;
        end
        B_PWAIT: begin
          if (mul_done) begin
            unique case (pidx)
              3'd0:    hwx  <= mul_p[63:0];
              3'd1:    hwy  <= mul_p[63:0];
              3'd2:    hwz  <= mul_p[63:0];
              3'd3:    hwxz <= mul_p[63:0];
              3'd4:    hwyz <= mul_p[63:0];
              default: hwzz <= mul_p[63:0];
            endcase
            pidx  <= pidx + 3'd1;
            state <= (pidx == 3'd5) ? B_UPD : B_PSTART;
          end
        end
        B_UPD: begin
          if (cur.remove) begin
            s_w   <= s_w - w64;    s_wx  <= s_wx - hwx;   s_wy  <= s_wy - hwy;
            s_wz  <= s_wz - hwz;   s_wxz <= s_wxz - hwxz; s_wyz <= s_wyz - hwyz;
            s_wzz <= s_wzz - hwzz;
            s_phi <= s_phi - {{8{cur.phi[15]}}, cur.phi};
            hc    <= hc - 7'd1;
            if (cur.unused && uc != 7'd0) uc <= uc - 7'd1;
          end else begin
            s_w   <= s_w + w64;    s_wx  <= s_wx + hwx;   s_wy  <= s_wy + hwy;
            s_wz  <= s_wz + hwz;   s_wxz <= s_wxz + hwxz; s_wyz <= s_wyz + hwyz;
            s_wzz <= s_wzz + hwzz;
            s_phi <= s_phi + {{8{cur.phi[15]}}, cur.phi};
            hc    <= hc + 7'd1;
            if (cur.unused) uc <= uc + 7'd1;
          end
          state <= B_FSTART;
        end
        B_FSTART: begin
          mul_a     <= fa;
          mul_b     <= fb;
          state     <= B_FWAIT;
        end
        B_FWAIT: begin
          if (mul_done) begin
            if (!fidx[0]) tmp <= mul_p;
            else if (fidx == 4'd1) den <= tmp - mul_p;
            else nums[2'(fidx[3:1] - 3'd1)] <= tmp - mul_p;
            fidx  <= fidx + 4'd1;
            state <= (fidx == 4'd9) ? B_DCHK : B_FSTART;
          end
        end
        B_DCHK: begin
          // replace a near-zero denominator by one
          if (dabs < DEN_THRESH) begin
            den_mag <= 128'd1;
            den_neg <= 1'b0;
            degen   <= 1'b1;
          end else begin
            den_mag <= dabs;
            den_neg <= den[127];
            degen   <= 1'b0;
          end
          didx  <= 3'd0;
          state <= B_DSTART;
        end
        B_DSTART: begin
          if (didx == 3'd4) begin
            if (hc == 7'd0) begin
              rphi  <= 16'd0;
              state <= B_FIN;
            end else begin
              div_num   <= {104'd0, phi_mag};
              div_den   <= {121'd0, hc};
              div_iters <= 8'd128;
              state     <= B_DWAIT;
            end
          end else begin
            div_num   <= nabs;
            div_den   <= den_mag;
            div_iters <= (didx < 3'd2) ? 8'd128 : 8'(128 + TX_SHIFT);
            state     <= B_DWAIT;
          end
        end
        B_DWAIT: begin
          if (div_done) begin
            unique case (didx)
              3'd0:    rx0  <= sat32(quo, qneg);
              3'd1:    ry0  <= sat32(quo, qneg);
              3'd2:    rtx  <= sat22(quo, qneg);
              3'd3:    rty  <= sat22(quo, qneg);
              default: rphi <= sat16(quo, s_phi[23]);
            endcase
            didx  <= didx + 3'd1;
            state <= (didx == 3'd4) ? B_FIN : B_DSTART;
          end
        end
        B_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            x_intercept  <= rx0;
            y_intercept  <= ry0;
            x_slope      <= rtx;
            y_slope      <= rty;
            mean_phi     <= rphi;
            hit_total    <= hc;
            unused_total <= uc;
            degenerate   <= degen;
            out_valid    <= 1'b1;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/weighted_line_fit_accumulator.sv
// Adds or removes one weighted hit per input beat and returns the updated straight-line
// fit (x0, y0, tx, ty), the mean phi and the hit counts as one result beat. Items are
// taken one at a time. An ignored one (add when full, remove when empty) skips the
// weight division and the hit products, and a fit with no hits skips the mean phi
// division. Most of the work is in the shared bit-serial divider, which produces one
// quotient bit per cycle for the weight (128 steps), the two intercepts (128 each), the
// two slopes (142 each) and the mean phi (128); the shared 32x32 multiplier forms the 16
// wide products. A stalled result holds the back end until the output register is free.
// A two-entry input queue keeps accepting beats while the back end is busy or a result
// waits to be taken, as long as the queue is not full.
module weighted_line_fit_accumulator import wlfa_pkg::*; #(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [14:0] z_pos,
  input  logic [15:0]        radius,
  input  logic signed [15:0] cos_phi,
  input  logic signed [15:0] sin_phi,
  input  logic [19:0]        hit_weight,
  input  logic signed [15:0] phi_angle,
  input  logic               is_unused,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_intercept,
  output logic signed [31:0] y_intercept,
  output logic signed [21:0] x_slope,
  output logic signed [21:0] y_slope,
  output logic signed [15:0] mean_phi,
  output logic [6:0]         hit_total,
  output logic [6:0]         unused_total,
  output logic               degenerate
);

  logic  q_ready;
  logic  q_push;
  item_t q_in;
  logic  q_valid;
  logic  q_pop;
  item_t q_out;

  wlfa_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .z_pos(z_pos), .radius(radius), .cos_phi(cos_phi), .sin_phi(sin_phi),
    .hit_weight(hit_weight), .phi_angle(phi_angle), .is_unused(is_unused),
    .q_ready(q_ready), .q_push(q_push), .q_item(q_in)
  );

  wlfa_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .item_in(q_in), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .item_out(q_out)
  );

  wlfa_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_out),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_intercept(x_intercept), .y_intercept(y_intercept),
    .x_slope(x_slope), .y_slope(y_slope), .mean_phi(mean_phi),
    .hit_total(hit_total), .unused_total(unused_total), .degenerate(degenerate)
  );

endmodule

>>> hdl/wlfa_check.sv
module wlfa_check import wlfa_pkg::*; #(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [6:0]        hit_total,
  input logic signed [15:0] mean_phi
);

  localparam int CAP = (MAX_HITS < 127) ? MAX_HITS : 127;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_total <= 7'(CAP))
    else $error("hit count above capacity");

  a_empty_phi: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_total == 7'd0 |-> mean_phi == 16'sd0)
    else $error("empty track with nonzero mean phi");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind weighted_line_fit_accumulator wlfa_check #(.MAX_HITS(MAX_HITS)) u_check (.*);

>>> sim/fit_result_checker.sv
module fit_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [14:0] z_pos,
  input  logic [15:0]        radius,
  input  logic signed [15:0] cos_phi,
  input  logic signed [15:0] sin_phi,
  input  logic [19:0]        hit_weight,
  input  logic signed [15:0] phi_angle,
  input  logic               is_unused,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] x_intercept,
  input  logic signed [31:0] y_intercept,
  input  logic signed [21:0] x_slope,
  input  logic signed [21:0] y_slope,
  input  logic signed [15:0] mean_phi,
  input  logic [6:0]         hit_total,
  input  logic [6:0]         unused_total,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wlfa_pkg::*;

  localparam int HIT_CAP = (MAX_HITS_DEF < 127) ? MAX_HITS_DEF : 127;

  typedef struct {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [21:0] tx;
    logic signed [21:0] ty;
    logic signed [15:0] mphi;
    logic [6:0]         hits;
    logic [6:0]         unused;
    logic               degen;
  } fit_t;

  fit_t fit_q[$];

  logic [63:0] s_w, s_wx, s_wy, s_wz, s_wxz, s_wyz, s_wzz;
  logic [23:0] s_phi;
  logic [6:0]  n_hits, n_unused;

  function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] sa, sb;
    sa = $signed({{64{a[63]}}, a});
    sb = $signed({{64{b[63]}}, b});
    return sa * sb;
  endfunction

  // quotient truncated toward zero, then clipped to a signed field of the given width
  function automatic longint fit_ratio(logic [127:0] num, logic [127:0] den,
                                       int shift, int width);
    logic         neg;
    logic [127:0] an, ad;
    logic [141:0] q, lim;
    neg = num[127] ^ den[127];
    an  = num[127] ? -num : num;
    ad  = den[127] ? -den : den;
    q   = ({14'd0, an} << shift) / {14'd0, ad};
    lim = 142'd1 << (width - 1);
    if (q == 0) return 0;
    if (neg) begin
      if (q > lim) q = lim;
      return -longint'(q[63:0]);
    end
    if (q > lim - 1) q = lim - 1;
    return longint'(q[63:0]);
  endfunction

  function automatic longint round_q14(longint p);
    if (p >= 0) return (p + 8192) / 16384;
    return -((-p + 8192) / 16384);
  endfunction

  task automatic accumulate_hit(logic rm, logic signed [14:0] z, logic [15:0] r_in,
                                logic signed [15:0] c, logic signed [15:0] s,
                                logic [19:0] hw, logic signed [15:0] phi, logic un);
    longint unsigned r, w;
    logic [63:0] x, y, uz, wx, wy, wz;
    logic act;
    r   = (r_in == 16'd0) ? 64'd1 : 64'(r_in);
    act = rm ? (n_hits > 0) : (n_hits < HIT_CAP);
    if (!act) return;
    x  = round_q14(longint'(r) * longint'(c));
    y  = round_q14(longint'(r) * longint'(s));
    uz = {{49{z[14]}}, z};
    w  = ({44'd0, hw} << W_SHIFT) / (r * r);
    wx = w * x;
    wy = w * y;
    wz = w * uz;
    if (!rm) begin
      s_w += w; s_wx += wx; s_wy += wy; s_wz += wz;
      s_wxz += wx * uz; s_wyz += wy * uz; s_wzz += wz * uz;
      s_phi = s_phi + {{8{phi[15]}}, phi};
      n_hits++;
      if (un) n_unused++;
    end else begin
      s_w -= w; s_wx -= wx; s_wy -= wy; s_wz -= wz;
      s_wxz -= wx * uz; s_wyz -= wy * uz; s_wzz -= wz * uz;
      s_phi = s_phi - {{8{phi[15]}}, phi};
      n_hits--;
      if (un && n_unused > 0) n_unused--;
    end
  endtask

  function automatic fit_t current_fit();
    fit_t f;
    logic [127:0] den, aden;
    longint sp, mp;
    den  = wide_mul(s_wzz, s_w) - wide_mul(s_wz, s_wz);
    aden = den[127] ? -den : den;
    f.degen = (aden < DEN_THRESH);
    if (f.degen) den = 128'd1;
    f.x0 = 32'(fit_ratio(wide_mul(s_wx, s_wzz) - wide_mul(s_wxz, s_wz), den, 0, 32));
    f.y0 = 32'(fit_ratio(wide_mul(s_wy, s_wzz) - wide_mul(s_wyz, s_wz), den, 0, 32));
    f.tx = 22'(fit_ratio(wide_mul(s_wxz, s_w) - wide_mul(s_wx, s_wz), den, TX_SHIFT, 22));
    f.ty = 22'(fit_ratio(wide_mul(s_wyz, s_w) - wide_mul(s_wy, s_wz), den, TX_SHIFT, 22));
    mp = 0;
    if (n_hits > 0) begin
      sp = longint'($signed(s_phi));
      mp = sp / longint'(n_hits);
      if (mp > 32767) mp = 32767;
      if (mp < -32768) mp = -32768;
    end
    f.mphi   = 16'(mp);
    f.hits   = n_hits;
    f.unused = n_unused;
    return f;
  endfunction

  task automatic report(string fld, longint want, longint got);
    errors++;
    if (errors <= 10)
      $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, fld, want, got);
  endtask

  always @(posedge clk) begin
    fit_t want;
    if (rst) begin
      errors = 0;
      pending = 0;
      s_w = 0; s_wx = 0; s_wy = 0; s_wz = 0; s_wxz = 0; s_wyz = 0; s_wzz = 0;
      s_phi = 0; n_hits = 0; n_unused = 0;
      fit_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (fit_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
        end else begin
          want = fit_q.pop_front();
          if (x_intercept !== want.x0) report("x_intercept", want.x0, x_intercept);
          if (y_intercept !== want.y0) report("y_intercept", want.y0, y_intercept);
          if (x_slope !== want.tx) report("x_slope", want.tx, x_slope);
          if (y_slope !== want.ty) report("y_slope", want.ty, y_slope);
          if (mean_phi !== want.mphi) report("mean_phi", want.mphi, mean_phi);
          if (hit_total !== want.hits) report("hit_total", want.hits, hit_total);
          if (unused_total !== want.unused)
            report("unused_total", want.unused, unused_total);
          if (degenerate !== want.degen) report("degenerate", want.degen, degenerate);
        end
      end
      if (in_valid && in_ready) begin
        accumulate_hit(op, z_pos, radius, cos_phi, sin_phi, hit_weight, phi_angle,
                       is_unused);
        fit_q.insert(fit_q.size(), current_fit());
      end
      pending = fit_q.size();
    end
  end
endmodule

>>> sim/tb_weighted_line_fit_accumulator.sv
module tb_weighted_line_fit_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  HIT_CAP    = wlfa_pkg::MAX_HITS_DEF;
  localparam int  RAND_HITS  = 1600;
  localparam longint CYCLE_LIMIT = 12000000;

  typedef struct {
    logic               op;
    logic signed [14:0] z;
    logic [15:0]        r;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [19:0]        hw;
    logic signed [15:0] phi;
    logic               un;
  } hit_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic op, is_unused, degenerate;
  logic signed [14:0] z_pos;
  logic [15:0] radius;
  logic signed [15:0] cos_phi, sin_phi, phi_angle, mean_phi;
  logic [19:0] hit_weight;
  logic signed [31:0] x_intercept, y_intercept;
  logic signed [21:0] x_slope, y_slope;
  logic [6:0] hit_total, unused_total;
  int errors, pending;
  longint cycles = 0;
  bit hold_request;

  hit_t track[$];
  int n_in_fit;

  weighted_line_fit_accumulator DUT (.*);

  fit_result_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls in varying moods, plus one long hold-off on request
  initial begin
    int hold, mood;
    bit held;
    hold = 0;
    mood = 0;
    held = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        hold = 6000;
        held = 1;
      end
      if ($urandom_range(0, 199) == 0) mood = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_ready = 0;
      end else if (mood == 0) out_ready = 1;
      else if (mood == 1) out_ready = ($urandom_range(0, 3) != 0);
      else out_ready = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_hit(hit_t h);
    bit ok;
    in_valid   = 1;
    op         = h.op;
    z_pos      = h.z;
    radius     = h.r;
    cos_phi    = h.c;
    sin_phi    = h.s;
    hit_weight = h.hw;
    phi_angle  = h.phi;
    is_unused  = h.un;
    forever begin
      #1 ok = in_ready;
      @(negedge clk);
      if (ok) break;
    end
    if (h.op == 0 && n_in_fit < HIT_CAP) n_in_fit++;
    if (h.op == 1 && n_in_fit > 0) n_in_fit--;
  endtask

  task automatic idle_gap(int n);
    in_valid = 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic hit_t make_hit(logic o, int z, int r, int c, int s, int hw, int phi,
                                    logic un);
    hit_t h;
    h.op = o; h.z = 15'(z); h.r = 16'(r); h.c = 16'(c); h.s = 16'(s); h.hw = 20'(hw);
    h.phi = 16'(phi); h.un = un;
    return h;
  endfunction

  function automatic hit_t random_hit();
    hit_t h;
    int ang;
    h.op = 0;
    h.z  = 15'(int'($urandom_range(0, 32000)) - 16000);
    case ($urandom_range(0, 5))
      0:       h.r = 16'($urandom_range(0, 15));
      1:       h.r = 16'($urandom_range(60000, 65535));
      default: h.r = 16'($urandom_range(8000, 45000));
    endcase
    ang = $urandom_range(0, 3);
    h.c = 16'((ang == 0) ? 16384 : (ang == 1) ? -16384 :
              int'($urandom_range(0, 32768)) - 16384);
    h.s = 16'(int'($urandom_range(0, 32768)) - 16384);
    case ($urandom_range(0, 5))
      0:       h.hw = 20'hFFFFF;
      1:       h.hw = 20'd0;
      default: h.hw = 20'($urandom_range(1, 1048575));
    endcase
    h.phi = 16'(int'($urandom_range(0, 51472)) - 25736);
    h.un  = 1'($urandom_range(0, 1));
    return h;
  endfunction

  task automatic add_hit(hit_t h);
    h.op = 0;
    send_hit(h);
    if (track.size() < HIT_CAP) track.insert(track.size(), h);
  endtask

  task automatic remove_hit(int idx);
    hit_t h;
    h = track[idx];
    track.delete(idx);
    h.op = 1;
    send_hit(h);
  endtask

  initial begin
    hit_t h;
    int sent, add_pct, seg, burst;
    rst = 1;
    in_valid = 0;
    op = 0; z_pos = 0; radius = 0; cos_phi = 0; sin_phi = 0;
    hit_weight = 0; phi_angle = 0; is_unused = 0;
    n_in_fit = 0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // remove on an empty fit is ignored
    send_hit(make_hit(1, 100, 5000, 16384, 0, 1000, 300, 1));
    // hit added as used, removed as unused: unused count stays at zero
    h = make_hit(0, 16000, 65535, 16384, -16384, 1048575, 25736, 0);
    send_hit(h);
    h.op = 1; h.un = 1;
    send_hit(h);
    // single hit and zero radius: degenerate fit
    add_hit(make_hit(0, -16000, 0, -16384, 16384, 1048575, -25736, 1));
    // second hit at the same z still leaves a zero denominator
    add_hit(make_hit(0, -16000, 1, 16384, -16384, 0, 25736, 1));
    add_hit(make_hit(0, 8000, 20000, 11585, 11585, 40000, 6434, 0));
    add_hit(make_hit(0, 0, 65535, 0, 16384, 1048575, 12868, 1));
    add_hit(make_hit(0, 16000, 30000, -11585, 11585, 500, -6434, 0));
    add_hit(make_hit(0, -8000, 1, 16384, 0, 1048575, 0, 1));
    add_hit(make_hit(0, 12345, 32768, -8192, -14189, 777, 25000, 1));
    remove_hit(track.size() - 1);
    remove_hit(0);
    while (track.size() > 0) remove_hit($urandom_range(0, track.size() - 1));
    // a single remove after the empty state again
    send_hit(make_hit(1, -1, 65535, -1, -1, 1048575, -1, 1));

    sent = 0;
    seg = 0;
    add_pct = 100;
    while (sent < RAND_HITS) begin
      if (sent % 150 == 0 && sent / 150 != seg) begin
        seg = sent / 150;
        add_pct = (seg % 4 == 1) ? 92 : (seg % 4 == 3) ? 25 : 60;
      end
      if (sent == 400) hold_request = 1;
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 4) begin
          // stray beat: remove of a hit never added, or add of a hit the track list does not record
          h = random_hit();
          h.op = 1'($urandom_range(0, 1));
          send_hit(h);
        end else if (track.size() == 0 ||
                     ($urandom_range(0, 99) < add_pct && track.size() < HIT_CAP)) begin
          add_hit(random_hit());
          sent++;
        end else if (track.size() >= HIT_CAP && $urandom_range(0, 1) == 0) begin
          add_hit(random_hit());
        end else begin
          remove_hit($urandom_range(0, track.size() - 1));
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
    end
    in_valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> weighted_line_fit_accumulator.f
hdl/wlfa_pkg.sv
hdl/wlfa_mul.sv
hdl/wlfa_div.sv
hdl/wlfa_front.sv
hdl/wlfa_queue.sv
hdl/wlfa_back.sv
hdl/weighted_line_fit_accumulator.sv
hdl/wlfa_check.sv
sim/fit_result_checker.sv
sim/tb_weighted_line_fit_accumulator.sv
